@@ src/bpa_pkg.sv @@
// Shared types, constants and codes for the buddy page allocator.
package bpa_pkg;

    localparam int NumOrdersDefault = 8;
    localparam int NumPagesDefault  = 128;
    localparam logic [31:0] PoolBaseReset = 32'h1000_0000;

    localparam logic [1:0] StatusOk      = 2'd0;
    localparam logic [1:0] StatusNoBlock = 2'd1;
    localparam logic [1:0] StatusBadSize = 2'd2;
    localparam logic [1:0] StatusBadFree = 2'd3;

    localparam logic OpAlloc = 1'b0;
    localparam logic OpFree  = 1'b1;

    typedef struct packed {
        logic start_alloc;
        logic start_free;
        logic search_step;
        logic split_step;
        logic alloc_commit;
        logic free_check;
        logic merge_step;
        logic free_commit;
    } bpa_cmd_t;

    typedef struct packed {
        logic size_bad;
        logic found;
        logic search_done;
        logic split_done;
        logic free_bad;
        logic merge_done;
    } bpa_stat_t;

endpackage

@@ src/buddy_page_allocator.sv @@
// Top level of the buddy page allocator.
// Allocation sizes the request, searches the free maps upward and splits the found block down to the
// needed order; a free checks the page and merges with free buddies upward; a rejected request ends in FAIL.
// One transaction at a time; the next is taken the cycle after the result has been taken.
// Reset: synchronous, active low; the pool becomes free blocks tiled from page 0,
// pool_base returns to 0x10000000, allocation orders stay undefined until written.
module buddy_page_allocator #(
    parameter int NUM_ORDERS = bpa_pkg::NumOrdersDefault,
    parameter int NUM_PAGES  = bpa_pkg::NumPagesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // op[0], size_kb[10:1], page_index[17:11], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], start_address[33:2], block_index[40:34],
                                   // block_order[43:41], zero pad
);
    import bpa_pkg::*;

    bpa_cmd_t    cmd;
    bpa_stat_t   stat;
    logic        load;
    logic [1:0]  res_status, m_status;
    logic [31:0] res_address, m_address;
    logic [6:0]  res_index, m_index;
    logic [2:0]  res_order, m_order;

    bpa_datapath #(.NUM_ORDERS(NUM_ORDERS), .NUM_PAGES(NUM_PAGES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_op(s_tdata[0]), .s_size_kb(s_tdata[10:1]), .s_page_index(s_tdata[17:11]),
        .load(load), .cmd(cmd), .stat(stat), .res_status(res_status),
        .res_address(res_address), .res_index(res_index), .res_order(res_order)
    );

    bpa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_op(s_tdata[0]), .stat(stat), .load(load), .cmd(cmd),
        .res_address(res_address), .res_index(res_index), .res_order(res_order),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_status(m_status),
        .m_address(m_address), .m_index(m_index), .m_order(m_order)
    );

    logic unused_status;
    assign unused_status = ^res_status;

    assign m_tdata = {4'd0, m_order, m_index, m_address, m_status};
endmodule

@@ src/bpa_datapath.sv @@
// Datapath of the buddy page allocator: free maps, allocation map and result.
module bpa_datapath #(
    parameter int NUM_ORDERS = bpa_pkg::NumOrdersDefault,
    parameter int NUM_PAGES  = bpa_pkg::NumPagesDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_op,
    input  logic [9:0]         s_size_kb,
    input  logic [6:0]         s_page_index,
    input  logic               load,
    input  bpa_pkg::bpa_cmd_t  cmd,
    output bpa_pkg::bpa_stat_t stat,
    output logic [1:0]         res_status,
    output logic [31:0]        res_address,
    output logic [6:0]         res_index,
    output logic [2:0]         res_order
);
    import bpa_pkg::*;

    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int OW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;

    // free map of one order after reset: the pool tiled from page 0 with the
    // largest aligned blocks that fit
    function automatic logic [NUM_PAGES-1:0] tile_map(int ord);
        logic [NUM_PAGES-1:0] m;
        int pos, o;
        m = '0;
        pos = 0;
        o = 0;
        for (int n = 0; n < NUM_PAGES; n++) begin
            if (pos < NUM_PAGES) begin
                o = NUM_ORDERS - 1;
                for (int k = 0; k < NUM_ORDERS; k++) begin
                    if (o > 0 && ((pos & ((1 << o) - 1)) != 0 ||
                        (1 << o) > NUM_PAGES - pos)) begin
                        o = o - 1;
                    end
                end
                if (o == ord) begin
                    m[pos] = 1'b1;
                end
                pos = pos + (1 << o);
            end
        end
        return m;
    endfunction

    logic [NUM_PAGES-1:0] free_reg [NUM_ORDERS];
    logic [NUM_PAGES-1:0] alloc_reg;
    logic [OW-1:0]        aorder_mem [NUM_PAGES];

    logic [9:0]    size_reg;
    logic [PW-1:0] page_reg;
    logic [OW-1:0] need_reg, ord_reg;
    logic [PW-1:0] idx_reg;
    logic [OW-1:0] rd_order_reg;
    logic [OW-1:0] found_order_reg;
    logic [31:0]   pool_base_reg;

    // needed order from page count
    logic [10:0] pages;
    logic [4:0]  need_w;
    logic        bad_size;
    always_comb begin
        pages = ({1'b0, size_reg} + 11'd3) >> 2;
        need_w = 5'd0;
        for (int k = 0; k < 12; k++) begin
            if ((11'd1 << k) < pages && need_w == 5'(k)) begin
                need_w = 5'(k + 1);
            end
        end
        bad_size = (size_reg == 10'd0) || (need_w >= 5'(NUM_ORDERS));
    end

    // lowest set bit of the current order's free map
    logic          hit;
    logic [PW-1:0] hit_idx;
    always_comb begin
        hit = 1'b0;
        hit_idx = '0;
        for (int p = NUM_PAGES - 1; p >= 0; p--) begin
            if (free_reg[ord_reg][p]) begin
                hit = 1'b1;
                hit_idx = PW'(p);
            end
        end
    end

    logic [PW:0] buddy_w;
    logic [PW:0] split_w;
    always_comb begin
        buddy_w = {1'b0, idx_reg} ^ ((PW+1)'(1) << ord_reg);
        split_w = {1'b0, idx_reg} + ((PW+1)'(1) << (ord_reg - OW'(1)));
    end

    assign stat.size_bad    = bad_size;
    assign stat.found       = hit;
    assign stat.search_done = (32'(ord_reg) + 1 >= NUM_ORDERS);
    assign stat.split_done  = (ord_reg <= need_reg);
    assign stat.free_bad    = (32'(page_reg) >= NUM_PAGES) || !alloc_reg[page_reg];
    assign stat.merge_done  = (32'(ord_reg) + 1 >= NUM_ORDERS) ||
                              (32'(buddy_w) >= NUM_PAGES) ||
                              !free_reg[ord_reg][buddy_w[PW-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg <= PoolBaseReset;
            alloc_reg <= '0;
            for (int o = 0; o < NUM_ORDERS; o++) begin
                free_reg[o] <= tile_map(o);
            end
        end else begin
            if (cfg_we) begin
                pool_base_reg <= cfg_wdata;
            end
            if (cmd.split_step) begin
                if (32'(split_w) < NUM_PAGES) begin
                    free_reg[ord_reg - OW'(1)][split_w[PW-1:0]] <= 1'b1;
                end
            end
            if (cmd.alloc_commit) begin
                free_reg[found_order_reg][idx_reg] <= 1'b0;
                alloc_reg[idx_reg] <= 1'b1;
            end
            if (cmd.free_check && !stat.free_bad) begin
                alloc_reg[page_reg] <= 1'b0;
            end
            if (cmd.merge_step) begin
                free_reg[ord_reg][buddy_w[PW-1:0]] <= 1'b0;
            end
            if (cmd.free_commit) begin
                free_reg[ord_reg][idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.alloc_commit) begin
            aorder_mem[idx_reg] <= need_reg;
        end
        if (cmd.start_free) begin
            rd_order_reg <= aorder_mem[PW'(s_page_index)];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            size_reg <= s_size_kb;
            page_reg <= PW'(s_page_index);
        end
        if (cmd.start_alloc) begin
            need_reg <= OW'(need_w);
            ord_reg  <= OW'(need_w);
        end
        if (cmd.search_step) begin
            if (hit) begin
                idx_reg         <= hit_idx;
                found_order_reg <= ord_reg;
            end else begin
                ord_reg <= ord_reg + OW'(1);
            end
        end
        if (cmd.split_step) begin
            ord_reg <= ord_reg - OW'(1);
        end
        if (cmd.free_check) begin
            idx_reg <= page_reg;
            ord_reg <= rd_order_reg;
        end
        if (cmd.merge_step) begin
            ord_reg <= ord_reg + OW'(1);
            if (buddy_w[PW-1:0] < idx_reg) begin
                idx_reg <= buddy_w[PW-1:0];
            end
        end
    end

    assign res_address = pool_base_reg + {13'd0, 7'(idx_reg), 12'd0};
    assign res_index   = 7'(idx_reg);
    assign res_order   = 3'(ord_reg);
    assign res_status  = StatusOk;

    logic unused_op;
    assign unused_op = s_op;
endmodule

@@ src/bpa_ctrl.sv @@
// Controller state machine of the buddy page allocator.
module bpa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_op,
    input  bpa_pkg::bpa_stat_t stat,
    output logic               load,
    output bpa_pkg::bpa_cmd_t  cmd,
    input  logic [31:0]        res_address,
    input  logic [6:0]         res_index,
    input  logic [2:0]         res_order,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [1:0]         m_status,
    output logic [31:0]        m_address,
    output logic [6:0]         m_index,
    output logic [2:0]         m_order
);
    import bpa_pkg::*;

    typedef enum logic [9:0] {
        IDLE    = 10'b0000000001,
        A_SIZE  = 10'b0000000010,
        A_FIND  = 10'b0000000100,
        A_SPLIT = 10'b0000001000,
        A_DONE  = 10'b0000010000,
        F_READ  = 10'b0000100000,
        F_CHECK = 10'b0001000000,
        F_MERGE = 10'b0010000000,
        F_DONE  = 10'b0100000000,
        FAIL    = 10'b1000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] fail_reg, fail_next;
    logic       out_valid_reg;
    logic       finish;
    logic [1:0] fin_status;

    assign s_tready = (state_reg == IDLE) && !out_valid_reg;
    assign load = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        fail_next  = fail_reg;
        cmd        = '0;
        finish     = 1'b0;
        fin_status = StatusOk;
        unique case (state_reg)
            IDLE: begin
                if (load) begin
                    if (s_op == OpFree) begin
                        cmd.start_free = 1'b1;
                        state_next = F_READ;
                    end else begin
                        state_next = A_SIZE;
                    end
                end
            end
            A_SIZE: begin
                if (stat.size_bad) begin
                    fail_next = StatusBadSize;
                    state_next = FAIL;
                end else begin
                    cmd.start_alloc = 1'b1;
                    state_next = A_FIND;
                end
            end
            A_FIND: begin
                cmd.search_step = 1'b1;
                if (stat.found) begin
                    state_next = A_SPLIT;
                end else if (stat.search_done) begin
                    fail_next = StatusNoBlock;
                    state_next = FAIL;
                end
            end
            A_SPLIT: begin
                if (stat.split_done) begin
                    cmd.alloc_commit = 1'b1;
                    state_next = A_DONE;
                end else begin
                    cmd.split_step = 1'b1;
                end
            end
            A_DONE: begin
                finish = 1'b1;
                state_next = IDLE;
            end
            F_READ: begin
                cmd.free_check = 1'b1;
                if (stat.free_bad) begin
                    fail_next = StatusBadFree;
                    state_next = FAIL;
                end else begin
                    state_next = F_CHECK;
                end
            end
            F_CHECK: begin
                state_next = F_MERGE;
            end
            F_MERGE: begin
                if (stat.merge_done) begin
                    cmd.free_commit = 1'b1;
                    state_next = F_DONE;
                end else begin
                    cmd.merge_step = 1'b1;
                end
            end
            F_DONE: begin
                finish = 1'b1;
                state_next = IDLE;
            end
            FAIL: begin
                finish = 1'b1;
                fin_status = fail_reg;
                state_next = IDLE;
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            fail_reg      <= StatusOk;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fail_reg  <= fail_next;
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_status <= fin_status;
            if (fin_status == StatusOk) begin
                m_address <= res_address;
                m_index   <= res_index;
                m_order   <= res_order;
            end else begin
                m_address <= '0;
                m_index   <= '0;
                m_order   <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;

    a_one_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != IDLE) |-> !s_tready)
        else $error("input taken while busy");
    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (state_reg == IDLE) && out_valid_reg)
        else $error("finish did not return to idle with result");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && fin_status != StatusOk) |=> (m_index == 7'd0 && m_order == 3'd0))
        else $error("failure result not cleared");
endmodule
